### hdl/assert_macros.svh
// assertion macros shared by the stream pattern replace modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SPR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define SPR_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### hdl/spr_pkg.sv
// shared types and constants for the stream pattern replace block
`default_nettype none

package spr_pkg;

  localparam int PATTERN_MAX_DEF     = 8;
  localparam int REPLACEMENT_MAX_DEF = 8;
  localparam int QUEUE_DEPTH         = 2;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LEN       = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LEN   = 2'd3;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_len;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_len;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/spr_queue.sv
// short command queue between the front and back parts
`default_nettype none
`include "assert_macros.svh"

module spr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  localparam int DEPTH = spr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SPR_ASSERT(a_cnt_in_range, clk, rst_n, cnt_r <= CW'(DEPTH), "queue count beyond depth")
  `SPR_ASSERT(a_ptr_agree, clk, rst_n, (cnt_r == '0 || cnt_r == CW'(DEPTH)) |-> wr_ptr_r == rd_ptr_r, "queue pointers disagree with count")

endmodule

`default_nettype wire

### hdl/spr_front.sv
// front part: sliding window, pattern compare and run command building
`default_nettype none
`include "assert_macros.svh"

module spr_front #(
  parameter int PATTERN_MAX     = spr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = spr_pkg::REPLACEMENT_MAX_DEF,
  parameter int RUN_MAX         = spr_pkg::PATTERN_MAX_DEF,
  parameter int CNT_W           = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire spr_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         in_end_of_stream,
  output logic                              cmd_valid,
  input  wire logic                         cmd_ready,
  output logic [RUN_MAX-1:0][7:0]           cmd_bytes,
  output logic [CNT_W-1:0]                  cmd_cnt
);

  localparam int FW  = $clog2(PATTERN_MAX + 1);
  localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW  = (FW > 4) ? FW : 4;
  localparam int RLW = (CNT_W > 4) ? CNT_W : 4;

  logic [PATTERN_MAX-1:0][7:0] win_r, win_nxt, wp, pat;
  logic [RUN_MAX-1:0][7:0]     rep;
  logic [FW-1:0]               fill_r, fill_nxt, fill1, len_eff, k;
  logic [LW-1:0]               len_w;
  logic [RLW-1:0]              rl_w;
  logic [CNT_W-1:0]            rl;
  logic                        line_open_r, line_open_nxt;
  logic                        match;
  logic                        accept;

  assign pat      = (PATTERN_MAX*8)'(cfg.pattern_bytes);
  assign rep      = (RUN_MAX*8)'(cfg.replacement_bytes);
  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;
  assign cmd_valid = in_valid && (cmd_cnt != '0);

  // effective lengths after the zero and saturation rules
  always_comb begin
    len_w = LW'(cfg.pattern_len);
    if (len_w == '0) begin
      len_w = LW'(1);
    end else if (len_w > LW'(PATTERN_MAX)) begin
      len_w = LW'(PATTERN_MAX);
    end
    len_eff = FW'(len_w);
    rl_w = RLW'(cfg.replacement_len);
    if (rl_w > RLW'(REPLACEMENT_MAX)) begin
      rl_w = RLW'(REPLACEMENT_MAX);
    end
    rl = CNT_W'(rl_w);
  end

  // window with the new byte (or the closing newline) appended
  always_comb begin
    wp = win_r;
    if (fill_r < FW'(PATTERN_MAX)) begin
      wp[fill_r[IW-1:0]] = in_end_of_stream ? spr_pkg::NEWLINE : in_byte;
    end
    fill1 = fill_r + FW'(1);
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (FW'(i) < len_eff) begin
        if (wp[i] != pat[i] || pat[i] == spr_pkg::NEWLINE) begin
          match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    line_open_nxt = line_open_r;
    cmd_bytes     = (RUN_MAX*8)'(wp);
    cmd_cnt       = '0;
    k             = '0;
    if (in_end_of_stream) begin
      cmd_cnt       = CNT_W'(fill_r) + CNT_W'(line_open_r);
      fill_nxt      = '0;
      line_open_nxt = 1'b0;
    end else begin
      line_open_nxt = (in_byte != spr_pkg::NEWLINE);
      if (fill1 >= len_eff) begin
        if (fill1 == len_eff && match) begin
          cmd_bytes = rep;
          cmd_cnt   = rl;
          fill_nxt  = '0;
        end else begin
          // oldest bytes leave until one short of the pattern length
          k        = fill1 - len_eff + FW'(1);
          cmd_cnt  = CNT_W'(k);
          win_nxt  = wp >> {k, 3'b000};
          fill_nxt = len_eff - FW'(1);
        end
      end else begin
        win_nxt  = wp;
        fill_nxt = fill1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      line_open_r <= 1'b0;
    end else if (accept) begin
      fill_r      <= fill_nxt;
      line_open_r <= line_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  `SPR_ASSERT(a_fill_below_max, clk, rst_n, fill_r < FW'(PATTERN_MAX), "window full between items")
  `SPR_ASSERT(a_eos_clears, clk, rst_n, accept && in_end_of_stream |=> fill_r == '0 && !line_open_r, "end of stream left state behind")

endmodule

`default_nettype wire

### hdl/spr_back.sv
// back part: plays out each queued run one byte per cycle into the output register, while the receiver is ready
`default_nettype none
`include "assert_macros.svh"

module spr_back #(
  parameter int RUN_MAX = spr_pkg::PATTERN_MAX_DEF,
  parameter int CNT_W   = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire logic [RUN_MAX-1:0][7:0] q_bytes,
  input  wire logic [CNT_W-1:0]       q_cnt,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_run
);

  localparam int IW = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          load;
  logic          last;

  assign load    = q_valid && (!out_valid_r || out_ready);
  assign last    = (CNT_W'(idx_r) + CNT_W'(1)) == q_cnt;
  assign q_ready = load && last;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? '0 : idx_r + IW'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= q_bytes[idx_r];
      out_last_r <= last;
    end
  end

  `SPR_ASSERT(a_run_held, clk, rst_n, idx_r != '0 |-> q_valid, "run left the queue mid-way")
  `SPR_ASSERT(a_idx_in_run, clk, rst_n, q_valid |-> CNT_W'(idx_r) < q_cnt, "byte index past run length")

endmodule

`default_nettype wire

### hdl/stream_pattern_replace.sv
// Streaming find-and-replace on a byte stream.
// Input channel (in_valid/in_ready): one text byte per item, or an end-of-stream
// item that flushes held bytes and closes an unterminated last line with a newline.
// Output channel (out_valid/out_ready): one byte per item; out_last_of_run marks
// the final byte caused by one input item. Items that cause nothing give no output.
// Configuration is a 64-bit APB-style port: pattern bytes at 0x00, pattern length
// at 0x08, replacement bytes at 0x10, replacement length at 0x18; pready is tied high.
// The first byte of an item's run passes through the run queue and then the output
// register before it appears on the output. Throughput: one item per cycle while
// each item yields at most one byte and the receiver is ready; a longer run is
// played out byte by byte through the single output register, and the two-entry
// run queue then fills and drops in_ready.
// When the receiver stalls the output register holds its byte, the queue fills and
// in_ready goes low; nothing is dropped.
// Reset: window empty, line closed, queue empty, pattern length 1, other config zero; data registers not reset.
`default_nettype none

module stream_pattern_replace #(
  parameter int PATTERN_MAX     = spr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = spr_pkg::REPLACEMENT_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_byte,
  input  wire logic                       in_end_of_stream,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_last_of_run,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [spr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [spr_pkg::CFG_DW-1:0] pwdata,
  output logic [spr_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int RUN_MAX = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);
  localparam int CMD_W   = RUN_MAX * 8 + CNT_W;

  spr_pkg::cfg_t cfg_r;
  logic [1:0]    reg_idx;
  logic          wr_en;

  logic                    cmd_valid, cmd_ready;
  logic [RUN_MAX-1:0][7:0] cmd_bytes, q_bytes;
  logic [CNT_W-1:0]        cmd_cnt, q_cnt;
  logic                    q_valid, q_ready;
  logic [CMD_W-1:0]        q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes     <= '0;
      cfg_r.pattern_len       <= 4'd1;
      cfg_r.replacement_bytes <= '0;
      cfg_r.replacement_len   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        spr_pkg::REG_PATTERN_BYTES:     cfg_r.pattern_bytes     <= pwdata;
        spr_pkg::REG_PATTERN_LEN:       cfg_r.pattern_len       <= pwdata[3:0];
        spr_pkg::REG_REPLACEMENT_BYTES: cfg_r.replacement_bytes <= pwdata;
        spr_pkg::REG_REPLACEMENT_LEN:   cfg_r.replacement_len   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spr_pkg::REG_PATTERN_BYTES:     prdata = cfg_r.pattern_bytes;
      spr_pkg::REG_PATTERN_LEN:       prdata = spr_pkg::CFG_DW'(cfg_r.pattern_len);
      spr_pkg::REG_REPLACEMENT_BYTES: prdata = cfg_r.replacement_bytes;
      spr_pkg::REG_REPLACEMENT_LEN:   prdata = spr_pkg::CFG_DW'(cfg_r.replacement_len);
      default:                        prdata = '0;
    endcase
  end

  spr_front #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX),
    .RUN_MAX         (RUN_MAX),
    .CNT_W           (CNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd_bytes        (cmd_bytes),
    .cmd_cnt          (cmd_cnt)
  );

  spr_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  ({cmd_cnt, cmd_bytes}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_bytes = q_data[RUN_MAX*8-1:0];
  assign q_cnt   = q_data[CMD_W-1:RUN_MAX*8];

  spr_back #(
    .RUN_MAX (RUN_MAX),
    .CNT_W   (CNT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_bytes         (q_bytes),
    .q_cnt           (q_cnt),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

### tb/sv/tb_stream_pattern_replace.sv
// testbench for stream_pattern_replace: random text streams checked against a byte-level predictor
`timescale 1ns / 100ps

module tb_stream_pattern_replace;

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_AT       = 50;
  localparam int HOLD_CYCLES   = 90;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } text_in_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_out_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_byte = 8'h00;
  logic                       in_end_of_stream = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [7:0]                 out_byte;
  logic                       out_last_of_run;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [spr_pkg::CFG_AW-1:0] paddr = '0;
  logic [spr_pkg::CFG_DW-1:0] pwdata = '0;
  logic [spr_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  // predictor state, tracks what the block holds
  spr_pkg::cfg_t cfg_m;
  logic [7:0]    win [spr_pkg::PATTERN_MAX_DEF];
  int unsigned   win_fill;
  bit            line_open;

  text_in_t  source_text[$];
  text_out_t replaced_text[$];

  int in_count, out_count, sent_items, items_queued, settings, fail_count, quiet;
  int in_gap, out_gap, hold_left;
  bit hold_done, calm;
  text_in_t cur_in;

  stream_pattern_replace dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .in_end_of_stream(in_end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic int unsigned eff_len(logic [3:0] l);
    if (l == 4'd0) return 1;
    if (l > spr_pkg::PATTERN_MAX_DEF) return spr_pkg::PATTERN_MAX_DEF;
    return l;
  endfunction

  // emit and remove the k oldest held bytes
  function automatic void shift_out(ref logic [7:0] run[$], input int unsigned k);
    int unsigned i;
    if (k > win_fill) k = win_fill;
    for (i = 0; i < k; i++) run.push_back(win[i]);
    for (i = k; i < win_fill; i++) win[i - k] = win[i];
    win_fill -= k;
  endfunction

  function automatic void find_replace_step(text_in_t it);
    logic [7:0]  run[$];
    int unsigned len, rl, k;
    bit          hit;
    if (it.eos) begin
      shift_out(run, win_fill);
      if (line_open) run.push_back(spr_pkg::NEWLINE);
      line_open = 1'b0;
    end else begin
      len = eff_len(cfg_m.pattern_len);
      line_open = (it.b != spr_pkg::NEWLINE);
      if (win_fill >= spr_pkg::PATTERN_MAX_DEF) shift_out(run, 1);
      win[win_fill] = it.b;
      win_fill++;
      if (win_fill > len) begin
        // pattern got shorter while bytes were held: flush unchecked
        shift_out(run, win_fill - len + 1);
      end else if (win_fill == len) begin
        hit = 1'b1;
        for (k = 0; k < len; k++)
          if (cfg_m.pattern_bytes[8*k +: 8] == spr_pkg::NEWLINE ||
              win[k] != cfg_m.pattern_bytes[8*k +: 8]) hit = 1'b0;
        if (hit) begin
          rl = (cfg_m.replacement_len > spr_pkg::REPLACEMENT_MAX_DEF) ?
               spr_pkg::REPLACEMENT_MAX_DEF : cfg_m.replacement_len;
          for (k = 0; k < rl; k++) run.push_back(cfg_m.replacement_bytes[8*k +: 8]);
          win_fill = 0;
        end else begin
          shift_out(run, 1);
        end
      end
    end
    for (k = 0; k < run.size(); k++)
      replaced_text.push_back('{b: run[k], last: (k == run.size() - 1)});
  endfunction

  function automatic logic [63:0] rand_pattern();
    logic [63:0] p;
    int k;
    p = {$urandom, $urandom};
    for (k = 0; k < 8; k++)
      if (p[8*k +: 8] == spr_pkg::NEWLINE) p[8*k +: 8] = ~spr_pkg::NEWLINE;
    return p;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_count == sent_items)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (source_text.size() > 0) begin
        cur_in = source_text.pop_front();
        in_valid <= 1'b1;
        in_byte <= cur_in.b;
        in_end_of_stream <= cur_in.eos;
        sent_items++;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!hold_done && in_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 17);
    end
  end

  // monitor: checks output items, predicts on input items, tracks register writes
  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (out_valid && out_ready) begin
        quiet = 0;
        out_count++;
        if (replaced_text.size() == 0) begin
          $error("unexpected output item: out_byte %02h out_last_of_run %0b",
                 out_byte, out_last_of_run);
          fail_count++;
        end else begin
          if (out_byte !== replaced_text[0].b) begin
            $error("out_byte: expected %02h, got %02h", replaced_text[0].b, out_byte);
            fail_count++;
          end
          if (out_last_of_run !== replaced_text[0].last) begin
            $error("out_last_of_run: expected %0b, got %0b",
                   replaced_text[0].last, out_last_of_run);
            fail_count++;
          end
          void'(replaced_text.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        quiet = 0;
        find_replace_step('{b: in_byte, eos: in_end_of_stream});
        in_count++;
      end
      if (psel && penable && pwrite && pready) begin
        quiet = 0;
        case (paddr[4:3])
          spr_pkg::REG_PATTERN_BYTES:     cfg_m.pattern_bytes = pwdata;
          spr_pkg::REG_PATTERN_LEN:       cfg_m.pattern_len = pwdata[3:0];
          spr_pkg::REG_REPLACEMENT_BYTES: cfg_m.replacement_bytes = pwdata;
          spr_pkg::REG_REPLACEMENT_LEN:   cfg_m.replacement_len = pwdata[3:0];
          default: ;
        endcase
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("** stream_pattern_replace: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] b);
    source_text.push_back('{b: b, eos: 1'b0});
    items_queued++;
  endtask

  task automatic push_eos();
    source_text.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b1});
    items_queued++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_regs(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb, logic [3:0] rl);
    cfg_write(spr_pkg::REG_PATTERN_BYTES, pb);
    cfg_write(spr_pkg::REG_PATTERN_LEN, {60'd0, pl});
    cfg_write(spr_pkg::REG_REPLACEMENT_BYTES, rb);
    cfg_write(spr_pkg::REG_REPLACEMENT_LEN, {60'd0, rl});
    settings++;
    @(posedge clk);
  endtask

  // block is idle once everything is accepted and delivered and the settle wait has passed
  task automatic wait_idle();
    do @(posedge clk);
    while (source_text.size() != 0 || in_valid || replaced_text.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // text built mostly from whole and partial copies of the pattern
  task automatic gen_text(int n);
    int start, plen, m, k, r;
    start = items_queued;
    plen = eff_len(cfg_m.pattern_len);
    while (items_queued - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        for (k = 0; k < plen; k++) push_byte(cfg_m.pattern_bytes[8*k +: 8]);
      end else if (r < 55) begin
        m = $urandom_range(1, plen);
        for (k = 0; k < m; k++) push_byte(cfg_m.pattern_bytes[8*k +: 8]);
      end else if (r < 70) begin
        k = $urandom_range(0, plen - 1);
        push_byte(cfg_m.pattern_bytes[8*k +: 8]);
      end else if (r < 78) begin
        push_byte(spr_pkg::NEWLINE);
      end else if (r < 83) begin
        push_eos();
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int k;
    string phrase;
    cfg_m = '{pattern_bytes: 64'd0, pattern_len: 4'd1,
              replacement_bytes: 64'd0, replacement_len: 4'd0};
    win_fill = 0;
    line_open = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings delete NUL bytes; flush with nothing held gives nothing
    push_eos();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte("A");
    push_byte(spr_pkg::NEWLINE);
    push_byte(8'h00);
    push_eos();
    push_eos();
    wait_idle();

    // three-byte pattern, full-length replacement
    program_regs(64'h0000_0000_0063_6261, 4'd3, 64'h5A59_5857_5655_5453, 4'd8);
    phrase = "abcaabcabx";
    for (k = 0; k < phrase.len(); k++) push_byte(phrase[k]);
    push_eos();
    wait_idle();

    // newline inside the pattern never matches
    program_regs(64'h0000_0000_0000_0A61, 4'd2, 64'h0000_0000_0000_007A, 4'd1);
    push_byte("a");
    push_byte(spr_pkg::NEWLINE);
    push_byte("a");
    push_eos();
    wait_idle();

    // zero pattern length acts as one, oversized replacement length saturates
    program_regs(64'h0000_0000_0000_00FF, 4'd0, 64'h0011_2233_4455_6677, 4'd15);
    push_byte(8'hFF);
    push_eos();
    wait_idle();

    // random text; the long receiver hold-off lands in this phase
    program_regs(rand_pattern(), 4'd1, {$urandom, $urandom}, 4'd8);
    gen_text(70);
    wait_idle();

    // longest pattern, matches deleted; leave seven bytes held at the end
    program_regs(rand_pattern(), 4'd8, {$urandom, $urandom}, 4'd0);
    gen_text(70);
    for (k = 0; k < 7; k++) push_byte(cfg_m.pattern_bytes[8*k +: 8]);
    wait_idle();

    // pattern shortened with bytes still held
    program_regs(rand_pattern(), 4'd1, {$urandom, $urandom}, 4'd3);
    gen_text(60);
    wait_idle();

    // oversized pattern length, all-ones pattern, all-zero replacement
    program_regs({64{1'b1}}, 4'd15, 64'd0, 4'd15);
    gen_text(60);
    wait_idle();

    program_regs(64'd0, 4'd0, {$urandom, $urandom}, 4'd1);
    gen_text(60);
    wait_idle();

    program_regs(rand_pattern(), 4'd4, {$urandom, $urandom}, 4'd2);
    gen_text(60);
    wait_idle();

    // final stretch runs at full rate on both sides
    calm = 1'b1;
    program_regs(rand_pattern(), 4'd3, {$urandom, $urandom}, 4'd5);
    gen_text(70);
    push_eos();
    wait_idle();

    if (replaced_text.size() != 0) begin
      $error("%0d expected output items never arrived", replaced_text.size());
      fail_count++;
    end
    $display("run covered %0d input items and %0d output items over %0d register settings",
             in_count, out_count, settings);
    $display("incl. length saturation, newline in pattern, shortened pattern, long stall");
    if (fail_count == 0) begin
      $display("** stream_pattern_replace: PASSED **");
    end else begin
      $display("** stream_pattern_replace: FAILED **");
    end
    $finish;
  end

endmodule
